// ===== rtl/sppseq_pkg.sv =====
// Shared types and constants for the stepper phase and position sequencer.
`default_nettype none

package sppseq_pkg;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_ADD_SET = 3'd1;
  localparam logic [2:0] OP_CLEAR   = 3'd2;
  localparam logic [2:0] OP_SET_POS = 3'd3;
  localparam logic [2:0] OP_SET_DIR = 3'd4;

  localparam logic [1:0] MODE_WAVE = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;

  localparam logic [1:0] DIR_STOP = 2'b00;
  localparam logic [1:0] DIR_FWD  = 2'b01;
  localparam logic [1:0] DIR_BACK = 2'b11;

  localparam logic       ADDR_STEP_MODE = 1'b0;
  localparam logic [7:0] DRIVE_OFF      = 8'hFF;

  typedef struct packed {
    logic [7:0]  phase;
    logic [7:0]  drive;
    logic [15:0] position;
  } step_t;

endpackage

`default_nettype wire

// ===== rtl/sppseq_step.sv =====
// One motor step: next phase counter, coil drive byte and position.
`default_nettype none

module sppseq_step (
  input  wire logic [1:0]          mode,
  input  wire logic                fwd,
  input  wire logic [7:0]          phase,
  input  wire logic [15:0]         position,
  output sppseq_pkg::step_t        step
);
  import sppseq_pkg::*;

  logic [7:0]  pc_half;
  logic [7:0]  pc_full;
  logic [7:0]  pc_half_p1;
  logic [1:0]  coil_a;
  logic [1:0]  coil_b;
  logic [3:0]  mask;
  logic [15:0] pos_even;

  always_comb begin
    pc_half    = fwd ? phase + 8'd1 : phase - 8'd1;
    pc_full    = fwd ? phase + 8'd2 : phase - 8'd2;
    pc_half_p1 = pc_half + 8'd1;
    // round toward zero to an even position
    if (!position[0]) begin
      pos_even = position;
    end else if (position[15]) begin
      pos_even = position + 16'd1;
    end else begin
      pos_even = {position[15:1], 1'b0};
    end
    if (mode == MODE_HALF) begin
      coil_a        = pc_half[2:1];
      coil_b        = pc_half_p1[2:1];
      mask          = (4'b0001 << coil_a) | (4'b0001 << coil_b);
      step.phase    = pc_half;
      step.position = fwd ? position + 16'd1 : position - 16'd1;
    end else begin
      coil_a = pc_full[2:1];
      coil_b = coil_a + 2'd1;
      if (mode == MODE_WAVE) begin
        mask = 4'b0001 << coil_a;
      end else begin
        mask = (4'b0001 << coil_a) | (4'b0001 << coil_b);
      end
      step.phase    = pc_full;
      step.position = fwd ? pos_even + 16'd2 : pos_even - 16'd2;
    end
    step.drive = {4'hF, ~mask};
  end

endmodule

`default_nettype wire

// ===== rtl/stepper_phase_position_sequencer.sv =====
// Top level: stepper phase and position sequencer with a config port.
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one request per cycle while out_tready is high; the output register frees as it is taken.
// The state update and step logic sit between the input handshake and the
// result register. Synchronous active-low reset: position, target, phase and
// direction clear, drive byte reads 0xFF, step mode returns to full step.
`default_nettype none

module stepper_phase_position_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [23:0] in_tdata,   // setpoint_increment[15:0], direction_request[17:16]
  input  wire logic [2:0]  in_tuser,   // operation[2:0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata,  // drive_byte[7:0], current_position[23:8],
                                       // current_direction[25:24]
  output      logic        out_tuser,  // step_made[0]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);
  import sppseq_pkg::*;

  logic [1:0]  mode_r;
  logic [7:0]  phase_r;
  logic [15:0] target_r;
  logic [15:0] pos_r;
  logic [1:0]  dir_r;
  logic [7:0]  drive_r;
  logic        out_valid_r;
  logic        made_r;

  logic [7:0]  phase_nxt;
  logic [15:0] target_nxt;
  logic [15:0] pos_nxt;
  logic [1:0]  dir_nxt;
  logic [7:0]  drive_nxt;
  logic        made_nxt;

  logic [2:0]  op;
  logic [15:0] inc;
  logic [1:0]  dreq;
  logic [15:0] tgt_tick;
  logic [15:0] err;
  logic        err_big;
  logic        fwd;
  logic        accept;
  logic        cfg_wr;
  step_t       step;

  assign op   = in_tuser;
  assign inc  = in_tdata[15:0];
  assign dreq = in_tdata[17:16];

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = made_r;
  assign out_tdata  = {6'd0, dir_r, pos_r, drive_r};

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == {1'b0, ADDR_STEP_MODE}) ? {30'd0, mode_r} : 32'd0;

  assign tgt_tick = target_r + {{14{dir_r[1]}}, dir_r};
  assign err      = tgt_tick - pos_r;
  assign err_big  = (mode_r == MODE_HALF) ? (err != 16'd0)
                  : !(err == 16'd0 || err == 16'd1 || err == 16'hFFFF);
  assign fwd      = !err[15] && (err != 16'd0);

  sppseq_step u_step (
    .mode     (mode_r),
    .fwd      (fwd),
    .phase    (phase_r),
    .position (pos_r),
    .step     (step)
  );

  always_comb begin
    phase_nxt  = phase_r;
    target_nxt = target_r;
    pos_nxt    = pos_r;
    dir_nxt    = dir_r;
    drive_nxt  = drive_r;
    made_nxt   = 1'b0;
    case (op)
      OP_TICK: begin
        target_nxt = tgt_tick;
        if (err_big) begin
          phase_nxt = step.phase;
          pos_nxt   = step.position;
          drive_nxt = step.drive;
          made_nxt  = 1'b1;
        end
      end
      OP_ADD_SET: target_nxt = target_r + inc;
      OP_CLEAR: begin
        target_nxt = 16'd0;
        pos_nxt    = 16'd0;
      end
      OP_SET_POS: target_nxt = pos_r;
      OP_SET_DIR: begin
        case (dreq)
          DIR_FWD:  dir_nxt = DIR_FWD;
          DIR_STOP: dir_nxt = DIR_STOP;
          default:  dir_nxt = DIR_BACK;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_FULL;
      phase_r     <= 8'd0;
      target_r    <= 16'd0;
      pos_r       <= 16'd0;
      dir_r       <= DIR_STOP;
      drive_r     <= DRIVE_OFF;
      made_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && cfg_paddr == {1'b0, ADDR_STEP_MODE}) begin
        mode_r <= cfg_pwdata[1:0];
      end
      if (accept) begin
        phase_r     <= phase_nxt;
        target_r    <= target_nxt;
        pos_r       <= pos_nxt;
        dir_r       <= dir_nxt;
        drive_r     <= drive_nxt;
        made_r      <= made_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_drive_high_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_tdata[7:4] == 4'hF))
    else $error("drive byte high nibble not all ones");

  a_step_coils: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && made_r) |->
      ($countones(~out_tdata[3:0]) == 1 || $countones(~out_tdata[3:0]) == 2))
    else $error("step drives a bad number of coils");

  a_no_step_on_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op != OP_TICK) |=> !made_r)
    else $error("step reported for a non-tick request");

  a_hold_unaccepted: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ($stable(pos_r) && $stable(target_r) && $stable(phase_r)))
    else $error("motor state changed without a request");
`endif

endmodule

`default_nettype wire

// ===== test/stepper_phase_position_sequencer_check.sv =====
// Checker for the stepper sequencer: predicts each result and compares it field by field.
`default_nettype none

module stepper_phase_position_sequencer_check
  import sppseq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,   // setpoint_increment[15:0], direction_request[17:16]
  input  wire logic [2:0]  in_tuser,   // operation[2:0]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,  // drive_byte[7:0], current_position[23:8],
                                       // current_direction[25:24]
  input  wire logic        out_tuser,  // step_made[0]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               failures,
  output int               pending,
  output int               steps_seen
);

  typedef struct packed {
    logic        made;
    logic [7:0]  drive;
    logic [15:0] position;
    logic [1:0]  direction;
  } motor_result_t;

  logic [7:0]  phase_count;
  logic [15:0] target_pos;
  logic [15:0] motor_pos;
  logic [1:0]  run_dir;
  logic [7:0]  drive_byte;
  logic [1:0]  step_mode;

  motor_result_t expected_results[$];
  motor_result_t want;
  int fail_count;
  int step_count;

  initial begin
    fail_count = 0;
    step_count = 0;
    failures   = 0;
    pending    = 0;
    steps_seen = 0;
  end

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] exp_val);
    $display("MISMATCH at %0t: %s got %h, want %h", $realtime, field, got, exp_val);
    fail_count++;
  endtask

  function automatic motor_result_t advance_motor(logic [2:0] op, logic [15:0] inc,
                                                  logic [1:0] dreq);
    motor_result_t r;
    logic [15:0]   gap;
    logic [3:0]    coils;
    logic          fwd;
    int            err;
    int            mag;
    int            tol;
    int            pp;
    int            pos;
    r.made = 1'b0;
    case (op)
      OP_TICK: begin
        target_pos = target_pos + {{14{run_dir[1]}}, run_dir};
        gap = target_pos - motor_pos;
        err = int'($signed(gap));
        mag = (err < 0) ? -err : err;
        tol = (step_mode == MODE_HALF) ? 0 : 1;
        if (mag > tol) begin
          fwd = (err > 0);
          pos = int'($signed(motor_pos));
          if (step_mode == MODE_HALF) begin
            phase_count = fwd ? phase_count + 8'd1 : phase_count - 8'd1;
            pp = int'(phase_count);
            coils = (4'b0001 << ((pp / 2) % 4)) | (4'b0001 << (((pp + 1) / 2) % 4));
            pos = pos + (fwd ? 1 : -1);
          end else begin
            phase_count = fwd ? phase_count + 8'd2 : phase_count - 8'd2;
            pp = int'(phase_count) / 2;
            coils = 4'b0001 << (pp % 4);
            if (step_mode != MODE_WAVE) coils = coils | (4'b0001 << ((pp + 1) % 4));
            pos = (pos / 2) * 2 + (fwd ? 2 : -2);
          end
          motor_pos = pos[15:0];
          drive_byte = {4'hF, ~coils};
          r.made = 1'b1;
        end
      end
      OP_ADD_SET: target_pos = target_pos + inc;
      OP_CLEAR: begin
        target_pos = '0;
        motor_pos  = '0;
      end
      OP_SET_POS: target_pos = motor_pos;
      OP_SET_DIR: begin
        case (dreq)
          DIR_FWD:  run_dir = DIR_FWD;
          DIR_STOP: run_dir = DIR_STOP;
          default:  run_dir = DIR_BACK;
        endcase
      end
      default: ;
    endcase
    r.drive     = drive_byte;
    r.position  = motor_pos;
    r.direction = run_dir;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      phase_count = '0;
      target_pos  = '0;
      motor_pos   = '0;
      run_dir     = DIR_STOP;
      drive_byte  = DRIVE_OFF;
      step_mode   = MODE_FULL;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request waiting", {15'd0, out_tuser}, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser) step_count++;
          if (out_tuser !== want.made)
            report_mismatch("step_made", {15'd0, out_tuser}, {15'd0, want.made});
          if (out_tdata[7:0] !== want.drive)
            report_mismatch("drive_byte", {8'd0, out_tdata[7:0]}, {8'd0, want.drive});
          if (out_tdata[23:8] !== want.position)
            report_mismatch("current_position", out_tdata[23:8], want.position);
          if (out_tdata[25:24] !== want.direction)
            report_mismatch("current_direction", {14'd0, out_tdata[25:24]},
                            {14'd0, want.direction});
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == {1'b0, ADDR_STEP_MODE})
        step_mode = cfg_pwdata[1:0];
      if (in_tvalid && in_tready)
        expected_results.push_back(advance_motor(in_tuser, in_tdata[15:0], in_tdata[17:16]));
    end
    failures   <= fail_count;
    pending    <= expected_results.size();
    steps_seen <= step_count;
  end

endmodule

`default_nettype wire

// ===== test/stepper_phase_position_sequencer_test.sv =====
// Testbench top for the stepper sequencer: clock, reset, stimulus, watchdog and verdict.
`default_nettype none

module stepper_phase_position_sequencer_test;
  import sppseq_pkg::*;

  localparam logic [1:0] MODE_UNDEF    = 2'd3;
  localparam logic [1:0] DIR_MINUS_TWO = 2'b10;
  localparam logic [2:0] OP_NONE_FIRST = 3'd5;
  localparam logic [2:0] OP_NONE_LAST  = 3'd7;
  localparam int         IDLE_LIMIT    = 2000;
  localparam int         PHASE_ITEMS   = 172;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic [23:0] in_tdata    = '0;  // setpoint_increment[15:0], direction_request[17:16]
  logic [2:0]  in_tuser    = '0;  // operation[2:0]
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [1:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  wire logic        in_tready;
  wire logic        out_tvalid;
  wire logic [31:0] out_tdata;    // drive_byte[7:0], current_position[23:8],
                                  // current_direction[25:24]
  wire logic        out_tuser;    // step_made[0]
  wire logic [31:0] cfg_prdata;
  wire logic        cfg_pready;

  int failures;
  int pending;
  int steps_seen;
  int requests_sent = 0;
  int idle_cycles   = 0;
  bit quiet         = 1'b0;

  always #5 clk = ~clk;

  stepper_phase_position_sequencer dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  stepper_phase_position_sequencer_check checker_i (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .failures, .pending, .steps_seen
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side: unless quiet, stall a random number of cycles before taking each result.
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_request(logic [2:0] op, logic [15:0] inc, logic [1:0] dreq);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, dreq, inc};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_step_mode(logic [1:0] mode);
    drain();
    repeat (2) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {1'b0, ADDR_STEP_MODE};
    cfg_pwdata  <= {30'd0, mode};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic send_random_request;
    int          pick;
    logic [15:0] inc;
    pick = $urandom_range(0, 99);
    inc  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)) - 16'd20;
    if (pick < 55)
      send_request(OP_TICK, 16'($urandom), 2'($urandom));
    else if (pick < 70)
      send_request(OP_ADD_SET, inc, 2'($urandom));
    else if (pick < 75)
      send_request(OP_CLEAR, 16'($urandom), 2'($urandom));
    else if (pick < 81)
      send_request(OP_SET_POS, 16'($urandom), 2'($urandom));
    else if (pick < 95)
      send_request(OP_SET_DIR, 16'($urandom), 2'($urandom));
    else
      send_request(3'($urandom_range(OP_NONE_FIRST, OP_NONE_LAST)), 16'($urandom), 2'($urandom));
  endtask

  initial begin
    logic [1:0] mode_plan[6];
    mode_plan = '{MODE_WAVE, MODE_HALF, MODE_UNDEF, MODE_FULL, MODE_HALF, MODE_WAVE};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset mode is full step.
    for (int op = OP_NONE_FIRST; op <= OP_NONE_LAST; op++)
      send_request(3'(op), 16'hFFFF, DIR_MINUS_TWO);
    send_request(OP_TICK, 16'h0000, DIR_STOP);
    send_request(OP_ADD_SET, 16'd3, DIR_STOP);
    send_request(OP_TICK, 16'h0000, DIR_STOP);
    send_request(OP_TICK, 16'h0000, DIR_STOP);
    send_request(OP_SET_DIR, 16'h0000, DIR_FWD);
    send_request(OP_TICK, 16'h0000, DIR_STOP);
    send_request(OP_TICK, 16'h0000, DIR_STOP);
    send_request(OP_SET_DIR, 16'h0000, DIR_MINUS_TWO);
    send_request(OP_SET_DIR, 16'h0000, DIR_BACK);
    send_request(OP_ADD_SET, 16'h7FFF, DIR_STOP);
    send_request(OP_ADD_SET, 16'h8000, DIR_STOP);
    send_request(OP_CLEAR, 16'h0000, DIR_STOP);
    send_request(OP_ADD_SET, 16'h8000, DIR_STOP);
    send_request(OP_TICK, 16'h0000, DIR_STOP);
    send_request(OP_SET_POS, 16'h0000, DIR_STOP);
    send_request(OP_SET_DIR, 16'h0000, DIR_STOP);
    send_request(OP_TICK, 16'h0000, DIR_STOP);

    foreach (mode_plan[i]) begin
      write_step_mode(mode_plan[i]);
      quiet = (i % 3 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 49) == 0) quiet = !quiet;
        send_random_request();
      end
    end
    quiet = 1'b0;

    drain();
    repeat (4) @(posedge clk);
    $display("Summary: %0d requests over wave, full, half and the undefined step mode",
             requests_sent);
    $display("Summary: %0d steps taken, %0d mismatches", steps_seen, failures);
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/sppseq_pkg.sv
rtl/sppseq_step.sv
rtl/stepper_phase_position_sequencer.sv
test/stepper_phase_position_sequencer_check.sv
test/stepper_phase_position_sequencer_test.sv
